// ===== design/hebbian_link_strength_update_macros.svh =====
// Assertion helpers for the Hebbian link strength update block.
`ifndef HEBBIAN_LINK_STRENGTH_UPDATE_MACROS_SVH
`define HEBBIAN_LINK_STRENGTH_UPDATE_MACROS_SVH

`ifndef SYNTHESIS
`define HLSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HLSU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HLSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/hlsu_pkg.sv =====
package hlsu_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int STRENGTH_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CONVERT_ENABLE       = 3'd0,
    CFG_CONVERSION_THRESHOLD = 3'd1,
    CFG_FOCUS_BOUNDARY       = 3'd2,
    CFG_MAX_IMPORTANCE       = 3'd3,
    CFG_DECAY_RATE           = 3'd4
  } cfg_reg_t;

  localparam logic                     CONVERT_ENABLE_RESET       = 1'b0;
  localparam logic [CFG_DATA_BITS-1:0] CONVERSION_THRESHOLD_RESET = 16'd15;
  localparam logic [CFG_DATA_BITS-1:0] FOCUS_BOUNDARY_RESET       = 16'd0;
  localparam logic [CFG_DATA_BITS-1:0] MAX_IMPORTANCE_RESET       = 16'd32767;
  localparam logic [CFG_DATA_BITS-1:0] DECAY_RATE_RESET           = 16'd3277;

endpackage

// ===== design/hebbian_link_strength_update.sv =====
// Hebbian link strength update, one link per transfer.
// Input channel (in_valid/in_ready): both endpoint importances, the old
// strength, the long-term importance and the link kind of one link.
// Output channel (out_valid/out_ready): new strength, kind change, resulting
// kind, endpoint swap and the invalid normalizer flag.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write registers only while no link is in flight.
// Throughput: one link per cycle while the output is not stalled. The
// pipeline depth is set by the two normalizing dividers, which retire one
// quotient bit per pipeline stage, followed by clamp, split multiply, sum,
// conjunction, mix multiply and rounding stages.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults:
// conversion off, threshold 15, boundary 0, maximum 32767, rate 3277.
`include "hebbian_link_strength_update_macros.svh"

module hebbian_link_strength_update import hlsu_pkg::*; #(
  parameter int IMPORTANCE_BITS = 16,
  parameter int FRACTION_BITS   = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [IMPORTANCE_BITS-1:0] importance_first,
  input  logic signed [IMPORTANCE_BITS-1:0] importance_second,
  input  logic [STRENGTH_BITS-1:0]         old_strength,
  input  logic signed [IMPORTANCE_BITS-1:0] long_term_importance,
  input  logic                             link_is_inverse,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [STRENGTH_BITS-1:0]         new_strength,
  output logic                             kind_changed,
  output logic                             result_is_inverse,
  output logic                             second_goes_first,
  output logic                             normalizer_invalid,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data
);

  localparam int IW   = IMPORTANCE_BITS;
  localparam int FW   = FRACTION_BITS;
  localparam int QW   = IW + FW;
  localparam int NW   = 2 * FW + 1;
  localparam int LW   = FW + 1;
  localparam int PW   = 2 * NW;
  localparam int CMPW = (QW > NW) ? QW : NW;
  localparam int CW   = FW + 2;
  localparam int SW   = 2 * FW + 4;

  localparam logic [FW:0]   ONE  = {1'b1, {FW{1'b0}}};
  localparam logic [NW-1:0] LIM  = {1'b1, {(2 * FW){1'b0}}};
  localparam logic [SW-1:0] HALF = SW'(ONE >> 1);

  typedef struct packed {
    logic        neg1;
    logic        neg2;
    logic        foc1;
    logic        foc2;
    logic        bad;
    logic        conv;
    logic        inv;
    logic [FW:0] old;
  } side_t;

  typedef struct packed {
    logic [IW-1:0] rem;
    logic [QW-1:0] dq;
  } lane_t;

  function automatic lane_t div_step(lane_t x, logic [IW-1:0] dv);
    logic [IW:0]   t;
    logic [IW+1:0] diff;
    lane_t         y;
    t    = {x.rem, x.dq[QW-1]};
    diff = {1'b0, t} - {2'b00, dv};
    y.dq  = {x.dq[QW-2:0], !diff[IW+1]};
    y.rem = diff[IW+1] ? t[IW-1:0] : diff[IW-1:0];
    return y;
  endfunction

  // configuration registers
  logic                     convert_enable;
  logic [CFG_DATA_BITS-1:0] conversion_threshold;
  logic [CFG_DATA_BITS-1:0] focus_boundary;
  logic [CFG_DATA_BITS-1:0] max_importance;
  logic [CFG_DATA_BITS-1:0] decay_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      convert_enable       <= CONVERT_ENABLE_RESET;
      conversion_threshold <= CONVERSION_THRESHOLD_RESET;
      focus_boundary       <= FOCUS_BOUNDARY_RESET;
      max_importance       <= MAX_IMPORTANCE_RESET;
      decay_rate           <= DECAY_RATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CONVERT_ENABLE:       convert_enable       <= cfg_data[0];
        CFG_CONVERSION_THRESHOLD: conversion_threshold <= cfg_data;
        CFG_FOCUS_BOUNDARY:       focus_boundary       <= cfg_data;
        CFG_MAX_IMPORTANCE:       max_importance       <= cfg_data;
        CFG_DECAY_RATE:           decay_rate           <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: hold everything while a result waits
  logic adv;
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  // entry
  logic signed [IW-1:0] bnd;
  logic signed [IW-1:0] top;
  logic signed [IW-1:0] thr;
  logic [IW:0]          a1;
  logic [IW:0]          a2;
  logic [IW:0]          dlt;
  side_t                side_in;
  lane_t                lane1_in;
  lane_t                lane2_in;

  assign bnd = IW'(focus_boundary);
  assign top = IW'(max_importance);
  assign thr = IW'(conversion_threshold);

  always_comb begin
    a1  = {importance_first[IW-1], importance_first} - {bnd[IW-1], bnd};
    a2  = {importance_second[IW-1], importance_second} - {bnd[IW-1], bnd};
    dlt = {top[IW-1], top} - {bnd[IW-1], bnd};
    side_in.neg1 = a1[IW];
    side_in.neg2 = a2[IW];
    side_in.foc1 = !a1[IW] && (a1 != '0);
    side_in.foc2 = !a2[IW] && (a2 != '0);
    side_in.bad  = dlt[IW] || (dlt == '0);
    side_in.conv = convert_enable && (long_term_importance < thr);
    side_in.inv  = link_is_inverse;
    side_in.old  = ({16'd0, old_strength} > 32'(ONE)) ? ONE : (FW + 1)'(old_strength);
    lane1_in.rem = '0;
    lane2_in.rem = '0;
    lane1_in.dq  = {(a1[IW] ? IW'(~a1 + 1'b1) : a1[IW-1:0]), {FW{1'b0}}};
    lane2_in.dq  = {(a2[IW] ? IW'(~a2 + 1'b1) : a2[IW-1:0]), {FW{1'b0}}};
  end

  // divider stages: index 0 is the entry register, then one quotient bit each
  logic [QW:0]   div_vld;
  side_t         div_side [QW+1];
  lane_t         div_l1   [QW+1];
  lane_t         div_l2   [QW+1];
  logic [IW-1:0] div_d    [QW+1];

  // clamp, split multiply, sum, conjunction, mix multiply
  logic                    cl_vld;
  logic                    mp_vld;
  logic                    sm_vld;
  logic                    cj_vld;
  logic                    mx_vld;
  side_t                   cl_side;
  side_t                   mp_side;
  side_t                   sm_side;
  side_t                   cj_side;
  side_t                   mx_side;
  logic [NW-1:0]           cl_n1;
  logic [NW-1:0]           cl_n2;
  logic                    cl_nz;
  logic [NW+LW-1:0]        mp_lo;
  logic [2*NW-LW-1:0]      mp_hi;
  logic                    mp_nz;
  logic [PW-1:0]           sm_prod;
  logic                    sm_nz;
  logic signed [CW-1:0]    cj_c;
  logic signed [SW-1:0]    mx_pa;
  logic [2*FW+1:0]         mx_pb;

  logic [CMPW-1:0]      q1_ext;
  logic [CMPW-1:0]      q2_ext;
  logic [NW-1:0]        n1_c;
  logic [NW-1:0]        n2_c;
  logic [FW:0]          cmag;
  logic                 czero;
  logic                 cneg;
  logic signed [CW-1:0] cc;
  logic [FW:0]          rate;
  logic [FW:0]          omr;
  logic signed [SW-1:0] s;
  logic [SW-1:0]        s_abs;
  logic [SW-1:0]        s_rnd;
  logic [FW:0]          m;
  logic                 t_neg;

  always_comb begin
    q1_ext = CMPW'(div_l1[QW].dq);
    q2_ext = CMPW'(div_l2[QW].dq);
    n1_c   = (q1_ext > CMPW'(LIM)) ? LIM : NW'(q1_ext);
    n2_c   = (q2_ext > CMPW'(LIM)) ? LIM : NW'(q2_ext);
    cmag   = (sm_prod > PW'(LIM)) ? ONE : sm_prod[2*FW:FW];
    czero  = sm_side.bad || !(sm_side.foc1 || sm_side.foc2) || !sm_nz;
    cneg   = (sm_side.neg1 ^ sm_side.neg2) ^ (sm_side.conv && sm_side.inv);
    cc     = czero ? '0 : (cneg ? -signed'(CW'(cmag)) : signed'(CW'(cmag)));
    rate   = ({16'd0, decay_rate} > 32'(ONE)) ? ONE : (FW + 1)'(decay_rate);
    omr    = ONE - rate;
    s      = mx_pa + signed'(SW'(mx_pb));
    s_abs  = s[SW-1] ? SW'(-s) : SW'(s);
    s_rnd  = s_abs + HALF;
    m      = s_rnd[2*FW:FW];
    t_neg  = s[SW-1] && (m != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld   <= '0;
      cl_vld    <= 1'b0;
      mp_vld    <= 1'b0;
      sm_vld    <= 1'b0;
      cj_vld    <= 1'b0;
      mx_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      div_vld   <= {div_vld[QW-1:0], in_valid};
      cl_vld    <= div_vld[QW];
      mp_vld    <= cl_vld;
      sm_vld    <= mp_vld;
      cj_vld    <= sm_vld;
      mx_vld    <= cj_vld;
      out_valid <= mx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_side[0] <= side_in;
      div_l1[0]   <= lane1_in;
      div_l2[0]   <= lane2_in;
      div_d[0]    <= dlt[IW-1:0];
      for (int k = 1; k <= QW; k++) begin
        div_side[k] <= div_side[k-1];
        div_d[k]    <= div_d[k-1];
        div_l1[k]   <= div_step(div_l1[k-1], div_d[k-1]);
        div_l2[k]   <= div_step(div_l2[k-1], div_d[k-1]);
      end
      cl_side <= div_side[QW];
      cl_n1   <= n1_c;
      cl_n2   <= n2_c;
      cl_nz   <= (q1_ext != '0) && (q2_ext != '0);
      mp_side <= cl_side;
      mp_lo   <= cl_n1 * cl_n2[LW-1:0];
      mp_hi   <= cl_n1 * cl_n2[NW-1:LW];
      mp_nz   <= cl_nz;
      sm_side <= mp_side;
      sm_prod <= PW'(mp_lo) + (PW'(mp_hi) << LW);
      sm_nz   <= mp_nz;
      cj_side <= sm_side;
      cj_c    <= cc;
      mx_side <= cj_side;
      mx_pa   <= signed'({1'b0, rate}) * cj_c;
      mx_pb   <= omr * mx_side.old;
      mx_pb   <= omr * cj_side.old;
      new_strength       <= STRENGTH_BITS'((!mx_side.conv && t_neg) ? '0 : m);
      kind_changed       <= mx_side.conv && t_neg;
      result_is_inverse  <= (mx_side.conv && t_neg) ? !mx_side.inv : mx_side.inv;
      second_goes_first  <= mx_side.conv && t_neg && !mx_side.inv
                            && mx_side.foc2 && !mx_side.foc1;
      normalizer_invalid <= mx_side.bad;
    end
  end

  logic [QW+6:0] pipe_vld;
  assign pipe_vld = {div_vld, cl_vld, mp_vld, sm_vld, cj_vld, mx_vld, out_valid};

  `HLSU_ASSERT_NEXT(a_stall_holds_pipe, out_valid && !out_ready, pipe_vld == $past(pipe_vld), "pipeline moved during output stall")
  `HLSU_ASSERT_NEXT(a_transfer_enters, in_valid && in_ready, div_vld[0], "accepted link did not enter the pipeline")
  `HLSU_ASSERT_IMPLY(a_swap_implies_turn, out_valid && second_goes_first, kind_changed && result_is_inverse, "endpoint swap without turn to inverse")
  `HLSU_ASSERT_IMPLY(a_bad_norm_no_change, out_valid && normalizer_invalid, !kind_changed, "kind change with invalid normalizer")

endmodule

// ===== tb/hebbian_link_strength_update_tb.sv =====
`timescale 1ns / 1ps

module hebbian_link_strength_update_tb;
  import hlsu_pkg::*;

  localparam int PIPE_LATENCY = 16 + 15 + 7;
  localparam int FRAC_BITS = 15;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int PHASES = 8;
  localparam int LINKS_PER_PHASE = 160;

  typedef struct packed {
    logic [15:0] imp_a;
    logic [15:0] imp_b;
    logic [15:0] old;
    logic [15:0] lti;
    logic        inv;
  } link_item_t;

  typedef struct packed {
    logic [15:0] strength;
    logic        changed;
    logic        inverse;
    logic        swap;
    logic        bad;
  } link_result_t;

  typedef struct packed {
    logic         is_write;
    cfg_reg_t     sel;
    logic [15:0]  value;
    link_item_t   link;
    logic         pinned;
    link_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] importance_first = '0;
  logic [15:0] importance_second = '0;
  logic [15:0] old_strength = '0;
  logic [15:0] long_term_importance = '0;
  logic        link_is_inverse = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] new_strength;
  logic        kind_changed;
  logic        result_is_inverse;
  logic        second_goes_first;
  logic        normalizer_invalid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = CFG_CONVERT_ENABLE;
  logic [15:0] cfg_data = '0;

  logic         row_pinned = 1'b0;
  link_result_t row_want = '0;

  logic        conf_convert = CONVERT_ENABLE_RESET;
  logic [15:0] conf_threshold = CONVERSION_THRESHOLD_RESET;
  logic [15:0] conf_boundary = FOCUS_BOUNDARY_RESET;
  logic [15:0] conf_max = MAX_IMPORTANCE_RESET;
  logic [15:0] conf_rate = DECAY_RATE_RESET;

  link_result_t pending_updates[$];
  stim_row_t    stimulus_rows[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 15;
  int           recv_idle_pct = 88;

  hebbian_link_strength_update DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .importance_first(importance_first),
    .importance_second(importance_second),
    .old_strength(old_strength),
    .long_term_importance(long_term_importance),
    .link_is_inverse(link_is_inverse),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .new_strength(new_strength),
    .kind_changed(kind_changed),
    .result_is_inverse(result_is_inverse),
    .second_goes_first(second_goes_first),
    .normalizer_invalid(normalizer_invalid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic link_result_t predict_update(link_item_t it);
    longint v1, v2, lti, bnd, top, thr, rate, old, d, a1, a2, n1, n2, prod, conj, s, mag, t;
    logic convert_mode;
    link_result_t r;
    v1 = $signed(it.imp_a);
    v2 = $signed(it.imp_b);
    lti = $signed(it.lti);
    bnd = $signed(conf_boundary);
    top = $signed(conf_max);
    thr = $signed(conf_threshold);
    rate = conf_rate;
    old = it.old;
    if (rate > ONE) rate = ONE;
    if (old > ONE) old = ONE;
    r = '0;
    r.inverse = it.inv;
    conj = 0;
    d = top - bnd;
    if (d <= 0) begin
      r.bad = 1'b1;
    end else if (v1 > bnd || v2 > bnd) begin
      a1 = v1 - bnd;
      a2 = v2 - bnd;
      n1 = ((a1 < 0) ? -a1 : a1) * ONE / d;
      n2 = ((a2 < 0) ? -a2 : a2) * ONE / d;
      if (n1 != 0 && n2 != 0) begin
        prod = (n2 > ONE * ONE / n1) ? ONE : (n1 * n2) / ONE;
        if (prod > ONE) prod = ONE;
        conj = ((a1 < 0) != (a2 < 0)) ? -prod : prod;
      end
    end
    convert_mode = conf_convert && (lti < thr);
    if (convert_mode && it.inv) conj = -conj;
    s = rate * conj + (ONE - rate) * old;
    mag = (((s < 0) ? -s : s) + ONE / 2) / ONE;
    t = (s < 0) ? -mag : mag;
    if (convert_mode && t < 0) begin
      r.changed = 1'b1;
      r.inverse = !it.inv;
      if (!it.inv) r.swap = (v2 > bnd) && !(v1 > bnd);
      t = -t;
    end else if (t < 0) begin
      t = 0;
    end
    r.strength = t[15:0];
    return r;
  endfunction

  function automatic link_result_t outcome(int strength, bit changed, bit inverse, bit swap,
                                           bit bad);
    return {16'(strength), changed, inverse, swap, bad};
  endfunction

  function automatic void add_link(int a, int b, int old, int lti, bit inv, bit pinned = 1'b0,
                                   link_result_t want = '0);
    stim_row_t row;
    row = '0;
    row.link = {16'(a), 16'(b), 16'(old), 16'(lti), inv};
    row.pinned = pinned;
    row.want = want;
    stimulus_rows.push_back(row);
  endfunction

  function automatic void add_write(cfg_reg_t sel, int value);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.sel = sel;
    row.value = 16'(value);
    stimulus_rows.push_back(row);
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int rand_importance(int bnd, int top);
    int span;
    span = (top > bnd) ? top - bnd : 100;
    case ($urandom_range(4))
      0: return int'($urandom_range(65535)) - 32768;
      1: return clamp16(bnd + int'($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return clamp16(bnd + int'($urandom_range(span)));
    endcase
  endfunction

  function automatic link_item_t random_link();
    int bnd, top, thr, old, lti;
    bnd = int'($signed(conf_boundary));
    top = int'($signed(conf_max));
    thr = int'($signed(conf_threshold));
    case ($urandom_range(7))
      0: old = $urandom_range(65535);
      1: old = $urandom_range(1) ? 0 : 32768;
      2, 3: old = $urandom_range(2000);
      default: old = $urandom_range(32768);
    endcase
    if ($urandom_range(1)) lti = clamp16(thr - 1 - int'($urandom_range(100)));
    else lti = int'($urandom_range(65535)) - 32768;
    return {16'(rand_importance(bnd, top)), 16'(rand_importance(bnd, top)), 16'(old),
            16'(lti), 1'($urandom_range(1))};
  endfunction

  task automatic send_link(link_item_t it, logic pinned, link_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    importance_first <= it.imp_a;
    importance_second <= it.imp_b;
    old_strength <= it.old;
    long_term_importance <= it.lti;
    link_is_inverse <= it.inv;
    row_pinned <= pinned;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_setting(cfg_reg_t sel, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    while (pending_updates.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    link_result_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {new_strength, kind_changed, result_is_inverse, second_goes_first,
               normalizer_invalid};
        if (pending_updates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result strength %0d chg %0b inv %0b swap %0b bad %0b",
                     $time, got.strength, got.changed, got.inverse, got.swap, got.bad);
        end else begin
          want = pending_updates.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected %0d/%0b/%0b/%0b/%0b got %0d/%0b/%0b/%0b/%0b", $time,
                       want.strength, want.changed, want.inverse, want.swap, want.bad,
                       got.strength, got.changed, got.inverse, got.swap, got.bad);
          end
        end
      end
      if (in_valid && in_ready)
        pending_updates.push_back(row_pinned ? row_want :
          predict_update({importance_first, importance_second, old_strength,
                          long_term_importance, link_is_inverse}));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONVERT_ENABLE: conf_convert = cfg_data[0];
          CFG_CONVERSION_THRESHOLD: conf_threshold = cfg_data;
          CFG_FOCUS_BOUNDARY: conf_boundary = cfg_data;
          CFG_MAX_IMPORTANCE: conf_max = cfg_data;
          CFG_DECAY_RATE: conf_rate = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int bnd, top;
    stim_row_t row;
    add_link(0, 0, 0, 0, 0, 1, outcome(0, 0, 0, 0, 0));
    add_link(32767, 32767, 0, 0, 0, 1, outcome(3277, 0, 0, 0, 0));
    add_link(32767, 32767, 32768, -32768, 0, 1, outcome(32768, 0, 0, 0, 0));
    add_link(0, 0, 65535, 32767, 0, 1, outcome(29491, 0, 0, 0, 0));
    add_link(-32768, -32768, 0, 0, 1, 1, outcome(0, 0, 1, 0, 0));
    add_link(32767, -32768, 32768, 0, 0);
    add_link(-32768, 32767, 0, 0, 0, 1, outcome(0, 0, 0, 0, 0));
    add_link(32767, 32767, 0, 0, 1, 1, outcome(3277, 0, 1, 0, 0));
    add_link(16384, 8192, 10000, 100, 0);
    add_link(1, 32767, 20000, -5, 1);
    add_write(CFG_MAX_IMPORTANCE, 0);
    add_link(32767, 32767, 32768, 0, 0, 1, outcome(29491, 0, 0, 0, 1));
    add_write(CFG_FOCUS_BOUNDARY, 32767);
    add_write(CFG_MAX_IMPORTANCE, -32768);
    add_link(-32768, 32767, 0, 0, 1, 1, outcome(0, 0, 1, 0, 1));
    add_write(CFG_FOCUS_BOUNDARY, -32768);
    add_write(CFG_MAX_IMPORTANCE, 32767);
    add_write(CFG_DECAY_RATE, 65535);
    add_link(32767, 32767, 0, 0, 0, 1, outcome(32768, 0, 0, 0, 0));
    add_link(-32768, 100, 12345, 0, 0);
    add_write(CFG_FOCUS_BOUNDARY, 0);
    add_write(CFG_DECAY_RATE, 0);
    add_link(32767, 32767, 12345, 0, 0, 1, outcome(12345, 0, 0, 0, 0));
    add_write(CFG_CONVERT_ENABLE, 1);
    add_write(CFG_DECAY_RATE, 32768);
    add_link(-32768, 32767, 0, 0, 0, 1, outcome(32768, 1, 1, 1, 0));
    add_link(32767, -32768, 0, 0, 0, 1, outcome(32768, 1, 1, 0, 0));
    add_link(-32768, 32767, 0, 0, 1, 1, outcome(32768, 0, 1, 0, 0));
    add_link(32767, 32767, 0, 14, 1, 1, outcome(32768, 1, 0, 0, 0));
    add_link(-32768, 32767, 0, 15, 0, 1, outcome(0, 0, 0, 0, 0));
    add_write(CFG_CONVERSION_THRESHOLD, -32768);
    add_link(-32768, 32767, 0, -32768, 0, 1, outcome(0, 0, 0, 0, 0));
    add_write(CFG_CONVERSION_THRESHOLD, 32767);
    add_write(CFG_DECAY_RATE, 3277);
    add_link(-20000, 30000, 1000, -32768, 0);
    add_link(30000, 30000, 500, 32766, 1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stimulus_rows[i]) begin
      row = stimulus_rows[i];
      if (row.is_write) begin
        settle();
        write_setting(row.sel, row.value);
      end else begin
        cfg_valid <= 1'b0;
        send_link(row.link, row.pinned, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 15 : ((p < 6) ? 88 : 0);
      recv_idle_pct = (p < 3) ? 88 : ((p < 6) ? 15 : 0);
      settle();
      case (p)
        0: begin
          write_setting(CFG_CONVERT_ENABLE, 1'b1);
          write_setting(CFG_CONVERSION_THRESHOLD, 16'h7FFF);
          write_setting(CFG_FOCUS_BOUNDARY, 16'h8000);
          write_setting(CFG_MAX_IMPORTANCE, 16'h7FFF);
          write_setting(CFG_DECAY_RATE, 16'd32768);
        end
        1: begin
          write_setting(CFG_CONVERT_ENABLE, 1'b1);
          write_setting(CFG_CONVERSION_THRESHOLD, 16'd200);
          write_setting(CFG_FOCUS_BOUNDARY, 16'd0);
          write_setting(CFG_MAX_IMPORTANCE, 16'd1);
          write_setting(CFG_DECAY_RATE, 16'hFFFF);
        end
        default: begin
          bnd = $urandom_range(3) ? int'($urandom_range(2000)) - 1000
                                  : int'($urandom_range(65535)) - 32768;
          if ($urandom_range(7) == 0) top = clamp16(bnd - int'($urandom_range(100)));
          else top = clamp16(bnd + 1 + int'($urandom_range(20000)));
          write_setting(CFG_CONVERT_ENABLE, 1'($urandom_range(1)));
          write_setting(CFG_CONVERSION_THRESHOLD,
                        $urandom_range(2) ? 16'(int'($urandom_range(400)) - 200)
                                          : 16'($urandom));
          write_setting(CFG_FOCUS_BOUNDARY, 16'(bnd));
          write_setting(CFG_MAX_IMPORTANCE, 16'(top));
          case ($urandom_range(3))
            0: write_setting(CFG_DECAY_RATE, 16'($urandom));
            1: write_setting(CFG_DECAY_RATE, $urandom_range(1) ? 16'd0 : 16'd32768);
            default: write_setting(CFG_DECAY_RATE, 16'($urandom_range(32768)));
          endcase
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (LINKS_PER_PHASE) send_link(random_link(), 1'b0, '0);
    end

    settle();
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
